// ===== hdl/stffa_pkg.sv =====
package stffa_pkg;

  localparam int REQ_W      = 3;
  localparam int ST_W       = 3;
  localparam int STEP_W     = 7;
  localparam int APB_DW     = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [REQ_W-1:0] REQ_PUT_FREE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUT_IDX  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_MARK     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_GET      = 3'd4;
  localparam logic [REQ_W-1:0] REQ_FIND     = 3'd5;
  localparam logic [REQ_W-1:0] REQ_EMPTY    = 3'd6;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [ST_W-1:0] ST_STATE    = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  localparam logic REG_GROW_STEP   = 1'b0;
  localparam logic REG_GROW_DOUBLE = 1'b1;

  localparam logic [STEP_W-1:0] GROW_STEP_RST = 7'd1;

  typedef struct packed {
    logic [STEP_W-1:0] grow_step;
    logic              grow_double;
  } cfg_t;

endpackage

// ===== hdl/stffa_ram.sv =====
module stffa_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/stffa_cfg.sv =====
module stffa_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stffa_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [stffa_pkg::APB_DW-1:0]      pwdata,
  output logic [stffa_pkg::APB_DW-1:0]      prdata,
  output logic                              pready,
  output stffa_pkg::cfg_t                   cfg
);
  import stffa_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic reg_sel;

  assign reg_sel = paddr[CFG_ADDR_W-1];

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_GROW_STEP:   cfg_nxt.grow_step   = pwdata[STEP_W-1:0];
        REG_GROW_DOUBLE: cfg_nxt.grow_double = pwdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grow_step   <= GROW_STEP_RST;
      cfg_r.grow_double <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GROW_STEP:   prdata = {{(APB_DW-STEP_W){1'b0}}, cfg_r.grow_step};
      REG_GROW_DOUBLE: prdata = {{(APB_DW-1){1'b0}}, cfg_r.grow_double};
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg    = cfg_r;

endmodule

// ===== hdl/stffa_ctrl.sv =====
module stffa_ctrl #(
  parameter int ENTRIES    = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stffa_pkg::cfg_t               cfg,
  input  logic                          start,
  output logic                          busy,
  input  logic [stffa_pkg::REQ_W-1:0]   req_type,
  input  logic [$clog2(ENTRIES)-1:0]    idx_in,
  input  logic [DATA_WIDTH-1:0]         wdata_in,
  output logic                          out_strobe,
  output logic [stffa_pkg::ST_W-1:0]    out_status,
  output logic [$clog2(ENTRIES)-1:0]    out_slot,
  output logic [DATA_WIDTH-1:0]         out_read_data,
  output logic [$clog2(ENTRIES+1)-1:0]  out_used_count,
  output logic [$clog2(ENTRIES+1)-1:0]  out_size
);
  import stffa_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int GROW_W = ((CNT_W > STEP_W) ? CNT_W : STEP_W) + 1;
  localparam int WORD_W = DATA_WIDTH + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_GROW  = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;

  localparam logic [CNT_W-1:0] CNT_ENTRIES = CNT_W'(ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(ENTRIES - 1);

  logic [2:0]            state_r, state_nxt;
  logic [REQ_W-1:0]      req_r, req_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0] wd_r, wd_nxt;
  logic [CNT_W-1:0]      size_r, size_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      scan_r, scan_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]      chk_r, chk_nxt;
  logic [IDX_W-1:0]      clr_r, clr_nxt;
  logic                  clr_emp_r, clr_emp_nxt;

  logic                  out_strobe_r;
  logic [ST_W-1:0]       out_status_r;
  logic [IDX_W-1:0]      out_slot_r;
  logic [DATA_WIDTH-1:0] out_rd_r;
  logic [CNT_W-1:0]      out_count_r;
  logic [CNT_W-1:0]      out_size_r;

  logic                  done;
  logic [ST_W-1:0]       res_status;
  logic [IDX_W-1:0]      res_slot;
  logic [DATA_WIDTH-1:0] res_rd;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;
  logic                  rd_valid;
  logic [DATA_WIDTH-1:0] rd_word;

  logic [STEP_W-1:0]     step_eff;
  logic [GROW_W-1:0]     grow_sum;
  logic [CNT_W-1:0]      grown;

  logic [CNT_W-1:0]      idx_in_ext;
  logic [CNT_W-1:0]      idx_r_ext;
  logic                  issue;
  logic                  hit;

  stffa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_valid   = ram_rdata[DATA_WIDTH];
  assign rd_word    = ram_rdata[DATA_WIDTH-1:0];
  assign idx_in_ext = CNT_W'(idx_in);
  assign idx_r_ext  = CNT_W'(idx_r);

  // one growth step, saturated at capacity
  always_comb begin
    step_eff = (cfg.grow_step == '0) ? STEP_W'(1) : cfg.grow_step;
    if (cfg.grow_double) begin
      grow_sum = (size_r == '0) ? GROW_W'(1) : (GROW_W'(size_r) << 1);
    end else begin
      grow_sum = GROW_W'(size_r) + GROW_W'(step_eff);
    end
    grown = (grow_sum > GROW_W'(ENTRIES)) ? CNT_ENTRIES : grow_sum[CNT_W-1:0];
  end

  assign issue = (scan_r < size_r);
  assign hit   = chk_vld_r && ((req_r == REQ_FIND) ? (rd_valid && (rd_word == wd_r))
                                                   : !rd_valid);

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    idx_nxt     = idx_r;
    wd_nxt      = wd_r;
    size_nxt    = size_r;
    count_nxt   = count_r;
    scan_nxt    = scan_r;
    chk_vld_nxt = chk_vld_r;
    chk_nxt     = chk_r;
    clr_nxt     = clr_r;
    clr_emp_nxt = clr_emp_r;
    done        = 1'b0;
    res_status  = ST_OK;
    res_slot    = '0;
    res_rd      = '0;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = {1'b1, wd_r};
    ram_raddr   = idx_in;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = req_type;
          idx_nxt = idx_in;
          wd_nxt  = wdata_in;
          case (req_type)
            REQ_PUT_FREE, REQ_FIND: begin
              state_nxt   = S_SCAN;
              scan_nxt    = '0;
              chk_vld_nxt = 1'b0;
            end
            REQ_PUT_IDX: begin
              if (idx_in_ext >= CNT_ENTRIES) begin
                done       = 1'b1;
                res_status = ST_FULL;
              end else if (idx_in_ext >= size_r) begin
                state_nxt = S_GROW;
              end else begin
                state_nxt = S_CHK;
              end
            end
            REQ_MARK, REQ_REMOVE, REQ_GET: begin
              if (idx_in_ext >= size_r) begin
                done       = 1'b1;
                res_status = ST_RANGE;
              end else begin
                state_nxt = S_CHK;
              end
            end
            REQ_EMPTY: begin
              state_nxt   = S_CLEAR;
              clr_nxt     = '0;
              clr_emp_nxt = 1'b1;
              size_nxt    = '0;
              count_nxt   = '0;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        ram_raddr = scan_r[IDX_W-1:0];
        if (hit) begin
          state_nxt = S_IDLE;
          done      = 1'b1;
          res_slot  = chk_r;
          if (req_r != REQ_FIND) begin
            ram_we    = 1'b1;
            ram_waddr = chk_r;
            count_nxt = count_r + CNT_W'(1);
          end
        end else if (!issue && !chk_vld_r) begin
          state_nxt = S_IDLE;
          done      = 1'b1;
          if (req_r == REQ_FIND) begin
            res_status = ST_NOTFOUND;
          end else if (size_r >= CNT_ENTRIES) begin
            res_status = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = size_r[IDX_W-1:0];
            size_nxt  = grown;
            count_nxt = count_r + CNT_W'(1);
            res_slot  = size_r[IDX_W-1:0];
          end
        end else if (issue) begin
          scan_nxt    = scan_r + CNT_W'(1);
          chk_vld_nxt = 1'b1;
          chk_nxt     = scan_r[IDX_W-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
        end
      end

      S_GROW: begin
        if (idx_r_ext >= size_r) begin
          size_nxt = grown;
        end else begin
          // slot lies above the old size, so it was free
          state_nxt = S_IDLE;
          ram_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          done      = 1'b1;
          res_slot  = idx_r;
        end
      end

      S_CHK: begin
        state_nxt = S_IDLE;
        done      = 1'b1;
        case (req_r)
          REQ_PUT_IDX: begin
            ram_we   = 1'b1;
            res_slot = idx_r;
            if (!rd_valid) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
          REQ_MARK: begin
            if (rd_valid) begin
              res_status = ST_STATE;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = {1'b1, rd_word};
              count_nxt = count_r + CNT_W'(1);
              res_slot  = idx_r;
            end
          end
          REQ_REMOVE: begin
            if (!rd_valid) begin
              res_status = ST_STATE;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = {1'b0, rd_word};
              count_nxt = count_r - CNT_W'(1);
              res_slot  = idx_r;
            end
          end
          REQ_GET: begin
            if (!rd_valid) begin
              res_status = ST_STATE;
            end else begin
              res_slot = idx_r;
              res_rd   = rd_word;
            end
          end
          default: begin
            res_status = ST_OK;
          end
        endcase
      end

      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + IDX_W'(1);
        if (clr_r == IDX_LAST) begin
          state_nxt   = S_IDLE;
          clr_emp_nxt = 1'b0;
          done        = clr_emp_r;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      clr_emp_r    <= 1'b0;
      size_r       <= '0;
      count_r      <= '0;
      chk_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      clr_emp_r    <= clr_emp_nxt;
      size_r       <= size_nxt;
      count_r      <= count_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_strobe_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    idx_r  <= idx_nxt;
    wd_r   <= wd_nxt;
    scan_r <= scan_nxt;
    chk_r  <= chk_nxt;
    if (done) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_rd_r     <= res_rd;
      out_count_r  <= count_nxt;
      out_size_r   <= size_nxt;
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_read_data  = out_rd_r;
  assign out_used_count = out_count_r;
  assign out_size       = out_size_r;

endmodule

// ===== hdl/slot_table_first_free_alloc_core.sv =====
// From start to strobe: out-of-range and unused requests answer from idle; in-range get,
// mark, remove and put at index read the slot first; put at index past the size first grows
// the size one growth step at a time; put free and find scan up to size entries (one entry
// per cycle from the slot RAM); empty clears every slot. A new request is taken in the cycle
// its predecessor's result is strobed. Reset: synchronous; a clearing pass (busy high)
// zeroes the slot RAM. Results last one cycle on out_strobe; the receiver cannot stall.
module slot_table_first_free_alloc_core #(
  parameter int ENTRIES    = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stffa_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [stffa_pkg::APB_DW-1:0]      pwdata,
  output logic [stffa_pkg::APB_DW-1:0]      prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic [stffa_pkg::REQ_W-1:0]       in_req_type,
  input  logic [$clog2(ENTRIES)-1:0]        in_slot_index_in,
  input  logic [DATA_WIDTH-1:0]             in_write_data,
  output logic                              out_strobe,
  output logic [stffa_pkg::ST_W-1:0]        out_status,
  output logic [$clog2(ENTRIES)-1:0]        out_slot_index_out,
  output logic [DATA_WIDTH-1:0]             out_read_data,
  output logic [$clog2(ENTRIES+1)-1:0]      out_used_count,
  output logic [$clog2(ENTRIES+1)-1:0]      out_size_in_use
);
  import stffa_pkg::*;

  cfg_t cfg;

  stffa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stffa_ctrl #(
    .ENTRIES    (ENTRIES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .start          (start),
    .busy           (busy),
    .req_type       (in_req_type),
    .idx_in         (in_slot_index_in),
    .wdata_in       (in_write_data),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_slot       (out_slot_index_out),
    .out_read_data  (out_read_data),
    .out_used_count (out_used_count),
    .out_size       (out_size_in_use)
  );

endmodule
